/* design/huffman_block_bit_packer_unit_defines.svh */
// Assertion macros used by the bit packer block store.
`ifndef HUFFMAN_BLOCK_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_BLOCK_BIT_PACKER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HBBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HBBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/hbbp_pkg.sv */
// Constants and types shared by the bit packer modules.
`timescale 1ns / 1ps

package hbbp_pkg;

    localparam int MAX_BLOCK_WORDS = 16;
    localparam int CODE_WIDTH      = 32;
    localparam int WORD_IDX_W      = $clog2(MAX_BLOCK_WORDS);
    localparam int ADDR_W          = WORD_IDX_W + 1;   // bank bit on top
    localparam int NWORDS_W        = $clog2(MAX_BLOCK_WORDS + 1);
    localparam int BP_W            = $clog2(MAX_BLOCK_WORDS * 64 + 1);

    localparam logic [15:0] TERMINAL_CEILING    = 16'd32768;
    localparam logic [8:0]  SYMBOL_TERMINAL_MAX = 9'd256;

    localparam logic       MODE_APPEND = 1'b0;
    localparam logic       MODE_FLUSH  = 1'b1;

    localparam logic [1:0] CFG_LOG2_BLOCK_BYTES = 2'd0;
    localparam logic [1:0] CFG_MAX_TERMINALS    = 2'd1;
    localparam logic [1:0] CFG_MAX_SYMBOLS      = 2'd2;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [63:0]       data;
    } mem_wr_t;

    typedef struct packed {
        logic                vld;
        logic                bank;
        logic [NWORDS_W-1:0] n_words;
        logic [14:0]         terms_m1;
    } close_cmd_t;

endpackage

/* design/huffman_block_bit_packer_unit.sv */
// Top level: MSB-first codeword packer into fixed-size zero-padded blocks.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser: mode; tdata: code_bits, code_length, terminal_count
//  m_*      out  m_tvalid/m_tready  tdata: word_data, word_index, terminals-1; tlast: last
//  cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
//  One input item per cycle. A closed block drains from its memory bank one word
//  per cycle, n = 2..16 words, through the registered read port and the output register.
//  An item that closes a block stalls while the previous block's reads are still issuing.
//  Reset empties the block at once via per-word valid bits; no clearing pass.
//  Output stalls back up into the drain; appends continue into the other bank.
`timescale 1ns / 1ps

module huffman_block_bit_packer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // code_bits[31:0], code_length[37:32], terminal_count[46:38], pad
    input  logic [0:0]  s_tuser,    // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,    // word_data[63:0], word_index[67:64], terminals-1[82:68], pad
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int BP_W = hbbp_pkg::BP_W;

    logic [2:0]  log2_bytes_reg;
    logic [15:0] max_terms_reg;
    logic [7:0]  max_syms_reg;

    logic [BP_W-1:0] bp_reg;
    logic [15:0]     term_reg;
    logic [7:0]      sym_reg;
    logic [63:0]     cur_reg;
    logic            fill_bank_reg;

    logic            s_mode;
    logic [31:0]     s_code;
    logic [5:0]      s_len;
    logic [8:0]      s_tc;
    logic [5:0]      len_c;
    logic [8:0]      terms_c;
    logic [hbbp_pkg::NWORDS_W-1:0] n_words;
    logic [BP_W-1:0] cap_bits;
    logic [15:0]     term_lim;
    logic            need_close;
    logic            accept;
    logic            do_close;
    logic            do_append;
    logic            drain_busy;

    logic [BP_W-1:0] base_bp;
    logic [63:0]     base_cur;
    logic [15:0]     base_term;
    logic [7:0]      base_sym;
    logic [31:0]     code_top;
    logic [127:0]    win;
    logic [6:0]      end_off;
    logic            word_done;

    hbbp_pkg::mem_wr_t    wr;
    hbbp_pkg::close_cmd_t close;

    assign s_mode = s_tuser[0];
    assign s_code = s_tdata[31:0];
    assign s_len  = s_tdata[37:32];
    assign s_tc   = s_tdata[46:38];

    assign len_c = (s_len > 6'(hbbp_pkg::CODE_WIDTH)) ? 6'(hbbp_pkg::CODE_WIDTH) : s_len;

    always_comb
    begin
        if (s_tc == 9'd0)
        begin
            terms_c = 9'd1;
        end
        else if (s_tc > hbbp_pkg::SYMBOL_TERMINAL_MAX)
        begin
            terms_c = hbbp_pkg::SYMBOL_TERMINAL_MAX;
        end
        else
        begin
            terms_c = s_tc;
        end
    end

    // sizes below 16 bytes act as 16
    always_comb
    begin
        case (log2_bytes_reg)
            3'd5:    n_words = hbbp_pkg::NWORDS_W'(4);
            3'd6:    n_words = hbbp_pkg::NWORDS_W'(8);
            3'd7:    n_words = hbbp_pkg::NWORDS_W'(16);
            default: n_words = hbbp_pkg::NWORDS_W'(2);
        endcase
    end

    assign cap_bits = {n_words, 6'd0};
    assign term_lim = (max_terms_reg > hbbp_pkg::TERMINAL_CEILING) ?
                      hbbp_pkg::TERMINAL_CEILING : max_terms_reg;

    assign need_close = (sym_reg != 8'd0) &&
                        ((s_mode == hbbp_pkg::MODE_FLUSH) ||
                         (({1'b0, bp_reg} + {{(BP_W - 5){1'b0}}, len_c}) > {1'b0, cap_bits}) ||
                         (({1'b0, term_reg} + {8'd0, terms_c}) > {1'b0, term_lim}) ||
                         (sym_reg >= max_syms_reg));

    assign s_tready  = !(need_close && drain_busy);
    assign accept    = s_tvalid && s_tready;
    assign do_close  = accept && need_close;
    assign do_append = accept && (s_mode == hbbp_pkg::MODE_APPEND);

    // a codeword after a close starts a fresh block
    assign base_bp   = do_close ? '0 : bp_reg;
    assign base_cur  = do_close ? 64'd0 : cur_reg;
    assign base_term = do_close ? 16'd0 : term_reg;
    assign base_sym  = do_close ? 8'd0 : sym_reg;

    // left-justify the code; bits above its length fall off the top
    assign code_top  = s_code << (6'd32 - len_c);
    assign win       = {base_cur, 64'd0} | ({code_top, 96'd0} >> base_bp[5:0]);
    assign end_off   = {1'b0, base_bp[5:0]} + {1'b0, len_c};
    assign word_done = end_off[6];

    // One write port suffices: a code in a fresh block never completes a word.
    always_comb
    begin
        wr = '0;
        if (do_close)
        begin
            wr.en   = !bp_reg[BP_W-1];
            wr.addr = {fill_bank_reg, bp_reg[BP_W-2:6]};
            wr.data = cur_reg;
        end
        else if (do_append && word_done)
        begin
            wr.en   = 1'b1;
            wr.addr = {fill_bank_reg, base_bp[BP_W-2:6]};
            wr.data = win[127:64];
        end
    end

    always_comb
    begin
        close.vld      = do_close;
        close.bank     = fill_bank_reg;
        close.n_words  = n_words;
        close.terms_m1 = 15'(term_reg - 16'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_bytes_reg <= 3'd6;
            max_terms_reg  <= 16'd32768;
            max_syms_reg   <= 8'd128;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hbbp_pkg::CFG_LOG2_BLOCK_BYTES: log2_bytes_reg <= cfg_data[2:0];
                hbbp_pkg::CFG_MAX_TERMINALS:    max_terms_reg  <= cfg_data;
                hbbp_pkg::CFG_MAX_SYMBOLS:      max_syms_reg   <= cfg_data[7:0];
                default:                        ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg        <= '0;
            term_reg      <= '0;
            sym_reg       <= '0;
            cur_reg       <= '0;
            fill_bank_reg <= 1'b0;
        end
        else
        begin
            if (do_close)
            begin
                fill_bank_reg <= ~fill_bank_reg;
            end
            if (do_append)
            begin
                bp_reg   <= base_bp + BP_W'(len_c);
                cur_reg  <= word_done ? win[63:0] : win[127:64];
                term_reg <= base_term + {7'd0, terms_c};
                sym_reg  <= base_sym + 8'd1;
            end
            else if (do_close)
            begin
                bp_reg   <= '0;
                cur_reg  <= '0;
                term_reg <= '0;
                sym_reg  <= '0;
            end
        end
    end

    hbbp_block_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .close    (close),
        .busy     (drain_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* design/hbbp_block_store.sv */
// Double-banked block word memory with drain reader and output register.
`timescale 1ns / 1ps
`include "huffman_block_bit_packer_unit_defines.svh"

module hbbp_block_store (
    input  logic                clk,
    input  logic                rst_n,
    input  hbbp_pkg::mem_wr_t    wr,
    input  hbbp_pkg::close_cmd_t close,
    output logic                busy,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [87:0]         m_tdata,   // word_data, word_index, block_terminals_minus_one, pad
    output logic                m_tlast
);

    localparam int DEPTH = 2 * hbbp_pkg::MAX_BLOCK_WORDS;

    logic [63:0] mem [DEPTH];
    logic [1:0][hbbp_pkg::MAX_BLOCK_WORDS-1:0] vld_reg, vld_next;

    logic                               drain_active_reg;
    logic                               drain_bank_reg;
    logic [hbbp_pkg::WORD_IDX_W-1:0]    drain_idx_reg;
    logic [hbbp_pkg::NWORDS_W-1:0]      drain_n_reg;
    logic [14:0]                        drain_terms_reg;

    logic                               rd_vld_reg;
    logic                               rd_mask_reg;
    logic [hbbp_pkg::WORD_IDX_W-1:0]    rd_index_reg;
    logic                               rd_last_reg;
    logic [14:0]                        rd_terms_reg;
    logic [63:0]                        mem_q_reg;

    logic                               out_vld_reg;
    logic [63:0]                        out_data_reg;
    logic [hbbp_pkg::WORD_IDX_W-1:0]    out_index_reg;
    logic [14:0]                        out_terms_reg;
    logic                               out_last_reg;

    logic adv_out;
    logic issue;
    logic is_last;

    assign adv_out = rd_vld_reg && (!out_vld_reg || m_tready);
    assign issue   = drain_active_reg && (!rd_vld_reg || adv_out);
    assign is_last = ({1'b0, drain_idx_reg} + hbbp_pkg::NWORDS_W'(1)) == drain_n_reg;
    assign busy    = drain_active_reg;

    // A bank's valid bits drop when it becomes the fill bank; unwritten words read as zero.
    always_comb
    begin
        vld_next = vld_reg;
        if (close.vld)
        begin
            vld_next[~close.bank] = '0;
        end
        if (wr.en)
        begin
            vld_next[wr.addr[hbbp_pkg::ADDR_W-1]][wr.addr[hbbp_pkg::WORD_IDX_W-1:0]] = 1'b1;
        end
    end

    // Fill writes never target the bank being drained, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (issue)
        begin
            mem_q_reg <= mem[{drain_bank_reg, drain_idx_reg}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            drain_active_reg <= 1'b0;
            drain_bank_reg   <= 1'b0;
            drain_idx_reg    <= '0;
            drain_n_reg      <= '0;
            drain_terms_reg  <= '0;
            rd_vld_reg       <= 1'b0;
            out_vld_reg      <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;

            if (close.vld)
            begin
                drain_active_reg <= 1'b1;
                drain_bank_reg   <= close.bank;
                drain_idx_reg    <= '0;
                drain_n_reg      <= close.n_words;
                drain_terms_reg  <= close.terms_m1;
            end
            else if (issue)
            begin
                if (is_last)
                begin
                    drain_active_reg <= 1'b0;
                end
                else
                begin
                    drain_idx_reg <= drain_idx_reg + hbbp_pkg::WORD_IDX_W'(1);
                end
            end

            if (issue)
            begin
                rd_vld_reg <= 1'b1;
            end
            else if (adv_out)
            begin
                rd_vld_reg <= 1'b0;
            end

            if (adv_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_mask_reg  <= vld_reg[drain_bank_reg][drain_idx_reg];
            rd_index_reg <= drain_idx_reg;
            rd_last_reg  <= is_last;
            rd_terms_reg <= is_last ? drain_terms_reg : 15'd0;
        end
        if (adv_out)
        begin
            out_data_reg  <= rd_mask_reg ? mem_q_reg : 64'd0;
            out_index_reg <= rd_index_reg;
            out_last_reg  <= rd_last_reg;
            out_terms_reg <= rd_terms_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_terms_reg, out_index_reg, out_data_reg};
    assign m_tlast  = out_last_reg;

    `HBBP_ASSERT_IMP(a_close_when_idle, close.vld, !drain_active_reg, "block closed while draining")
    `HBBP_ASSERT_IMP(a_no_write_drain_bank, wr.en && drain_active_reg,
        wr.addr[hbbp_pkg::ADDR_W-1] != drain_bank_reg, "write into bank being drained")
    `HBBP_ASSERT_NXT(a_read_lands, issue, rd_vld_reg, "issued read did not land")
    `HBBP_ASSERT_NXT(a_read_held, rd_vld_reg && out_vld_reg && !m_tready,
        rd_vld_reg && $stable(rd_index_reg), "read word lost under output stall")

endmodule

/* tb/huffman_block_bit_packer_unit_checker.sv */
// Bit packer checker: tracks the streams, predicts each block word and compares.
`timescale 1ns / 1ps

module huffman_block_bit_packer_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,    // code_bits[31:0], code_length[37:32], terminal_count[46:38], pad
    input  logic [0:0]  s_tuser,    // mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,    // word_data[63:0], word_index[67:64], terminals-1[82:68], pad
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending
);

    typedef struct {
        logic [63:0] data;
        logic [3:0]  idx;
        logic [14:0] terms_m1;
        logic        last;
    } block_word_t;

    logic [2:0]  log2_bytes;
    logic [15:0] term_limit;
    logic [7:0]  sym_limit;

    logic [63:0] blk_buf [hbbp_pkg::MAX_BLOCK_WORDS];
    int unsigned bit_pos;
    int unsigned blk_terms;
    int unsigned blk_syms;

    block_word_t expected_words [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic int unsigned block_words();
        int unsigned k;
        int unsigned w;
        k = log2_bytes;
        if (k < 4)
            k = 4;
        w = 1 << (k - 3);
        if (w > hbbp_pkg::MAX_BLOCK_WORDS)
            w = hbbp_pkg::MAX_BLOCK_WORDS;
        return w;
    endfunction

    task automatic clear_block();
        for (int i = 0; i < hbbp_pkg::MAX_BLOCK_WORDS; i++)
            blk_buf[i] = '0;
        bit_pos   = 0;
        blk_terms = 0;
        blk_syms  = 0;
    endtask

    task automatic close_block();
        int unsigned n;
        block_word_t w;
        n = block_words();
        for (int unsigned i = 0; i < n; i++)
        begin
            w.data     = blk_buf[i];
            w.idx      = i[3:0];
            w.last     = (i + 1 == n);
            w.terms_m1 = w.last ? 15'(blk_terms - 1) : 15'd0;
            expected_words = {expected_words, w};
        end
        clear_block();
    endtask

    task automatic pack_item(logic mode, logic [31:0] code, logic [5:0] len_in,
                             logic [8:0] tc_in);
        int unsigned len;
        int unsigned terms;
        int unsigned cap;
        int unsigned lim;
        if (mode == hbbp_pkg::MODE_FLUSH)
        begin
            if (blk_syms > 0)
                close_block();
            return;
        end
        len = len_in;
        if (len > hbbp_pkg::CODE_WIDTH)
            len = hbbp_pkg::CODE_WIDTH;
        terms = tc_in;
        if (terms == 0)
            terms = 1;
        if (terms > hbbp_pkg::SYMBOL_TERMINAL_MAX)
            terms = hbbp_pkg::SYMBOL_TERMINAL_MAX;
        cap = block_words() * 64;
        lim = term_limit;
        if (lim > hbbp_pkg::TERMINAL_CEILING)
            lim = hbbp_pkg::TERMINAL_CEILING;

        // an empty block always takes the symbol, limits or not
        if (blk_syms > 0 && (bit_pos + len > cap || blk_terms + terms > lim ||
                             blk_syms >= sym_limit))
            close_block();

        // bits past a shrunken block are dropped but still advance the position
        for (int b = len; b > 0; b--)
        begin
            if (bit_pos < cap && code[b-1])
                blk_buf[(bit_pos >> 6) & (hbbp_pkg::MAX_BLOCK_WORDS - 1)][63 - (bit_pos & 63)] = 1'b1;
            bit_pos++;
        end
        blk_terms += terms;
        blk_syms = (blk_syms + 1) & 8'hFF;
    endtask

    task automatic report(string field, logic [63:0] exp_val, logic [63:0] act_val);
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_val, act_val);
        errors++;
    endtask

    task automatic check_word();
        block_word_t w;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected word, expected none, got %h", $time, m_tdata);
            errors++;
            return;
        end
        w = expected_words.pop_front();
        if (m_tdata[63:0] !== w.data)
            report("word_data", w.data, m_tdata[63:0]);
        if (m_tdata[67:64] !== w.idx)
            report("word_index", 64'(w.idx), 64'(m_tdata[67:64]));
        if (m_tdata[82:68] !== w.terms_m1)
            report("block_terminals_minus_one", 64'(w.terms_m1), 64'(m_tdata[82:68]));
        if (m_tdata[87:83] !== 5'd0)
            report("tdata pad", 64'd0, 64'(m_tdata[87:83]));
        if (m_tlast !== w.last)
            report("tlast", 64'(w.last), 64'(m_tlast));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_bytes = 3'd6;
            term_limit = 16'd32768;
            sym_limit  = 8'd128;
            clear_block();
            expected_words.delete();
            pending <= 0;
        end
        else
        begin
            // output first: a word leaving now cannot stem from an item entering now
            if (m_tvalid && m_tready)
                check_word();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hbbp_pkg::CFG_LOG2_BLOCK_BYTES: log2_bytes = cfg_data[2:0];
                    hbbp_pkg::CFG_MAX_TERMINALS:    term_limit = cfg_data;
                    hbbp_pkg::CFG_MAX_SYMBOLS:      sym_limit  = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                pack_item(s_tuser[0], s_tdata[31:0], s_tdata[37:32], s_tdata[46:38]);
            pending <= expected_words.size();
        end
    end

endmodule

/* tb/huffman_block_bit_packer_unit_test.sv */
// Bit packer testbench top: clock, reset, stimulus, backpressure and verdict.
`timescale 1ns / 1ps

module huffman_block_bit_packer_unit_test;

    localparam int          DRAIN_CYCLES  = 40;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_ITEMS   = 24;
    localparam logic [1:0]  CFG_RESERVED  = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [47:0] s_tdata = '0;
    logic [0:0]  s_tuser = hbbp_pkg::MODE_APPEND;
    logic        m_tready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = hbbp_pkg::CFG_LOG2_BLOCK_BYTES;
    logic [15:0] cfg_data = '0;

    logic        s_tready;
    logic        m_tvalid;
    logic [87:0] m_tdata;
    logic        m_tlast;
    logic        cfg_ready;

    int errors;
    int pending;
    bit tx_calm = 1'b0;
    bit rx_calm = 1'b0;

    huffman_block_bit_packer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    huffman_block_bit_packer_unit_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("huffman_block_bit_packer_unit_test: errors");
        $finish;
    end

    // word sink: random stall before each item, none while rx_calm
    initial
    begin
        int stall;
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
        end
    end

    // keeps valid high across back-to-back items
    task automatic send_item(logic mode, logic [31:0] code, logic [5:0] len, logic [8:0] tc);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, tc, len, code};
        do @(posedge clk); while (s_tready !== 1'b1);
    endtask

    task automatic append(logic [31:0] code, logic [5:0] len, logic [8:0] tc);
        send_item(hbbp_pkg::MODE_APPEND, code, len, tc);
    endtask

    // flush ignores the codeword fields, so they carry noise
    task automatic flush();
        send_item(hbbp_pkg::MODE_FLUSH, $urandom, 6'($urandom), 9'($urandom));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (cfg_ready !== 1'b1);
    endtask

    // unused upper bits of the narrow registers carry noise
    task automatic configure(logic [2:0] log2_bytes, logic [15:0] term_lim,
                             logic [7:0] sym_lim);
        write_reg(hbbp_pkg::CFG_LOG2_BLOCK_BYTES, {13'($urandom), log2_bytes});
        write_reg(hbbp_pkg::CFG_MAX_TERMINALS, term_lim);
        write_reg(hbbp_pkg::CFG_MAX_SYMBOLS, {8'($urandom), sym_lim});
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_RESERVED, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [2:0]  rnd_log2;
        logic [15:0] rnd_terms;
        logic [7:0]  rnd_syms;
        logic [5:0]  len;
        logic [8:0]  tc;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: extremes of the codeword fields
        append(32'hFFFF_FFFF, 6'd32, 9'd256);
        append(32'h0000_0001, 6'd1, 9'd1);
        append(32'hDEAD_BEEF, 6'd0, 9'd0);          // no bits, terminal count zero
        append(32'hA5A5_A5A5, 6'd63, 9'd511);       // clipped length and terminals
        append(32'h0000_0000, 6'd33, 9'd257);
        append(32'hFFFF_FFF5, 6'd4, 9'd3);          // bits above the length ignored
        flush();
        flush();                                    // empty block: no words
        settle();

        // smallest block, zero limits: one symbol per block
        configure(3'd0, 16'd0, 8'd0);
        append(32'h8000_0001, 6'd32, 9'd1);
        append(32'h0000_007F, 6'd7, 9'd256);
        append(32'h0000_0003, 6'd2, 9'd2);
        flush();
        settle();

        // largest block, terminal limit above the ceiling, then shrink while open
        configure(3'd7, 16'hFFFF, 8'hFF);
        for (int i = 0; i < 10; i++)
            append($urandom, 6'd32, 9'($urandom_range(1, 256)));
        settle();
        configure(3'd5, 16'd32768, 8'd128);
        append($urandom, 6'd8, 9'd1);
        flush();
        settle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            tx_calm = (phase % 3 == 1);
            rx_calm = (phase % 3 == 2);
            rnd_log2 = 3'($urandom_range(0, 7));
            case ($urandom_range(0, 4))
                0: rnd_terms = 16'd0;
                1: rnd_terms = 16'd1;
                2: rnd_terms = 16'($urandom_range(2, 2000));
                3: rnd_terms = 16'd32768;
                default: rnd_terms = 16'($urandom_range(32769, 65535));
            endcase
            case ($urandom_range(0, 4))
                0: rnd_syms = 8'd0;
                1: rnd_syms = 8'd1;
                2: rnd_syms = 8'($urandom_range(2, 20));
                3: rnd_syms = 8'd128;
                default: rnd_syms = 8'($urandom_range(129, 255));
            endcase
            configure(rnd_log2, rnd_terms, rnd_syms);

            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    flush();
                else
                begin
                    case ($urandom_range(0, 19))
                        0: len = 6'd0;
                        1: len = 6'($urandom_range(33, 63));
                        default: len = 6'($urandom_range(1, 32));
                    endcase
                    case ($urandom_range(0, 19))
                        0: tc = 9'd0;
                        1: tc = 9'($urandom_range(257, 511));
                        2: tc = 9'd256;
                        default: tc = 9'($urandom_range(1, 256));
                    endcase
                    append($urandom, len, tc);
                end
            end
            flush();
            settle();
        end

        if (errors == 0 && pending == 0)
            $display("huffman_block_bit_packer_unit_test: clean");
        else
            $display("huffman_block_bit_packer_unit_test: errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/hbbp_pkg.sv
design/hbbp_block_store.sv
design/huffman_block_bit_packer_unit.sv
tb/huffman_block_bit_packer_unit_checker.sv
tb/huffman_block_bit_packer_unit_test.sv
